>>> rtl/affine_matrix_transform_unit_top_assert.svh
// Assertion macros shared by the affine transform RTL.
`ifndef AFFINE_MATRIX_TRANSFORM_UNIT_TOP_ASSERT_SVH
`define AFFINE_MATRIX_TRANSFORM_UNIT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define AMT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define AMT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/amt_pkg.sv
`timescale 1ns / 1ps

package amt_pkg;

    localparam int CMD_W       = 3;
    localparam int FIELD_W     = 32;
    localparam int ANGLE_W     = 19;
    localparam int IN_TDATA_W  = 280;
    localparam int OUT_TDATA_W = 256;
    localparam int OUT_TUSER_W = 2;

    localparam logic [CMD_W-1:0] CMD_IDENTITY  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ROTATE    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TRANSLATE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_APPLY     = 3'd5;
    localparam logic [CMD_W-1:0] CMD_INVERT    = 3'd6;

    // CORDIC runs in Q30 on a 34-bit signed word.
    localparam int CW               = 34;
    localparam int CORDIC_MAX_STEPS = 25;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 19'sd205887;

    localparam logic [30:0] ATAN_Q30 [CORDIC_MAX_STEPS] = '{
        31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
        31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
        31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536,
        31'd32768, 31'd16384, 31'd8192, 31'd4096, 31'd2048,
        31'd1024, 31'd512, 31'd256, 31'd128, 31'd64
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_CFIN,
        ST_MAC,
        ST_COMMIT,
        ST_DLOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PR_APPEND,
        PR_APPLY,
        PR_INV
    } prog_t;

endpackage

>>> rtl/affine_matrix_transform_unit_top.sv
// Identity, load and the unused code go straight to the result; apply, append and translate
// run through the shared multiply/add unit, rotate runs the CORDIC first, and invert computes
// determinant and numerators, then, unless singular, each coefficient in a one-bit-per-cycle divider.
// Products and sums share one multiply/add unit; CORDIC and the divider use their own adders.
// One command is in work at a time; the next is taken when the sequencer is back in idle.
// rst_n clears the sequencer and output valid and sets the stored matrix to identity.
`timescale 1ns / 1ps
`include "affine_matrix_transform_unit_top_assert.svh"

module affine_matrix_transform_unit_top #(
    parameter int COEF_WIDTH   = 32,
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // arg_a, arg_b, arg_c, arg_d, arg_e, arg_f, point_x, point_y, angle, zero fill
    input  logic [amt_pkg::IN_TDATA_W-1:0]     s_tdata,
    // command
    input  logic [amt_pkg::CMD_W-1:0]          s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // res_a, res_b, res_c, res_d, res_e, res_f, out_x, out_y
    output logic [amt_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // singular, is_identity
    output logic [amt_pkg::OUT_TUSER_W-1:0]    m_tuser
);
    import amt_pkg::*;

    localparam int W     = COEF_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int QW    = W + F;
    localparam int SW    = (2 * W > W + F) ? 2 * W : W + F;
    localparam int NSTEP = (CORDIC_STEPS < CORDIC_MAX_STEPS) ? CORDIC_STEPS : CORDIC_MAX_STEPS;
    localparam int CIW   = $clog2(NSTEP);
    localparam int DCW   = $clog2(QW + 1);

    typedef logic signed [W-1:0] coef_t;

    localparam logic signed [63:0] VMAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
    localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;
    localparam coef_t VMAX = W'(VMAX64);
    localparam coef_t VMIN = W'(VMIN64);
    localparam logic [SW-1:0] POS_LIM = SW'(VMAX64);
    localparam logic [SW-1:0] NEG_LIM = POS_LIM + SW'(1);

    function automatic coef_t sat64(input logic signed [63:0] v);
        if (v > VMAX64) return VMAX;
        if (v < VMIN64) return VMIN;
        return W'(v);
    endfunction

    localparam coef_t ONE_C = sat64(64'sd1 <<< F);

    function automatic coef_t addsat(input coef_t a, input coef_t b);
        return sat64(64'(a) + 64'(b));
    endfunction

    function automatic coef_t negsat(input coef_t a);
        return sat64(-64'(a));
    endfunction

    function automatic logic [W-1:0] magw(input coef_t a);
        return a[W-1] ? W'(-a) : W'(a);
    endfunction

    // Saturate an unsigned magnitude with a separate sign.
    function automatic coef_t ssat(input logic [SW-1:0] m, input logic ng);
        if (ng) begin
            if (m > NEG_LIM) return VMIN;
            return W'(SW'(0) - m);
        end
        if (m > POS_LIM) return VMAX;
        return W'(m);
    endfunction

    function automatic coef_t mulq(input coef_t x, input coef_t y);
        logic [2*W-1:0] p;
        p = (2 * W)'(magw(x)) * (2 * W)'(magw(y));
        return ssat(SW'(p >> F), x[W-1] ^ y[W-1]);
    endfunction

    function automatic logic [31:0] sat32(input coef_t v);
        logic signed [63:0] e;
        e = 64'(v);
        if (e > 64'sd2147483647) return 32'h7fff_ffff;
        if (e < -64'sd2147483648) return 32'h8000_0000;
        return e[31:0];
    endfunction

    // Sequencer and datapath registers.
    state_t           state_reg, state_next;
    prog_t            prog_reg, prog_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [2:0]       j_reg, j_next;
    logic [1:0]       t_reg, t_next;
    logic             ph_reg, ph_next;
    coef_t            acc_reg, acc_next;
    coef_t            prod_reg, prod_next;
    coef_t            mat_reg [6];
    coef_t            mat_next [6];
    coef_t            op_reg [6];
    coef_t            op_next [6];
    coef_t            tmp_reg [6];
    coef_t            tmp_next [6];
    coef_t            num_reg [6];
    coef_t            num_next [6];
    coef_t            inv_reg [6];
    coef_t            inv_next [6];
    coef_t            ox_reg, ox_next, oy_reg, oy_next, det_reg, det_next;
    coef_t            px_reg, px_next, py_reg, py_next;
    logic             sing_reg, sing_next;
    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [CIW-1:0]   ci_reg, ci_next;
    logic             flip_reg, flip_next;
    logic [QW-1:0]    dvd_reg, dvd_next, quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [DCW-1:0]   dcnt_reg, dcnt_next;
    logic [2:0]       dk_reg, dk_next;
    logic             dneg_reg, dneg_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [OUT_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    // Operand decode for the shared unit.
    coef_t      dec_x, dec_y;
    logic       dec_direct, dec_neg, dec_base0, dec_jend;
    logic [1:0] dec_last;
    coef_t      mac_val;
    logic       mac_fin, prog_fin, out_load, mat_ident;
    logic [W-1:0] ud;
    logic [W:0]   trial, diff;
    logic         div_ge;

    coef_t in_arg [6];
    coef_t in_px, in_py;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            in_arg[i] = sat64(64'($signed(s_tdata[FIELD_W*i +: FIELD_W])));
        end
        in_px = sat64(64'($signed(s_tdata[FIELD_W*6 +: FIELD_W])));
        in_py = sat64(64'($signed(s_tdata[FIELD_W*7 +: FIELD_W])));
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign mat_ident = (mat_reg[0] == ONE_C) && (mat_reg[1] == '0) && (mat_reg[2] == '0) &&
                       (mat_reg[3] == ONE_C) && (mat_reg[4] == '0) && (mat_reg[5] == '0);

    always_comb
    begin
        dec_x      = '0;
        dec_y      = '0;
        dec_direct = 1'b0;
        dec_neg    = 1'b0;
        dec_base0  = (t_reg == 2'd0);
        dec_last   = 2'd0;
        dec_jend   = 1'b0;
        unique case (prog_reg)
            PR_APPEND:
            begin
                dec_last = (j_reg < 3'd4) ? 2'd1 : 2'd2;
                dec_jend = (j_reg == 3'd5);
                if (t_reg == 2'd2)
                begin
                    dec_direct = 1'b1;
                    dec_x      = op_reg[{2'b10, j_reg[0]}];
                end
                else
                begin
                    dec_x = mat_reg[{j_reg[2:1], t_reg[0]}];
                    dec_y = op_reg[{1'b0, t_reg[0], j_reg[0]}];
                end
            end
            PR_APPLY:
            begin
                dec_last = 2'd2;
                dec_jend = (j_reg == 3'd1);
                if (t_reg == 2'd2)
                begin
                    dec_direct = 1'b1;
                    dec_x      = mat_reg[{2'b10, j_reg[0]}];
                end
                else
                begin
                    dec_x = mat_reg[{1'b0, t_reg[0], j_reg[0]}];
                    dec_y = t_reg[0] ? py_reg : px_reg;
                end
            end
            default:
            begin
                dec_jend = (j_reg == 3'd6);
                unique case (j_reg)
                    3'd0:
                    begin
                        dec_last = 2'd1;
                        dec_x    = t_reg[0] ? mat_reg[2] : mat_reg[0];
                        dec_y    = t_reg[0] ? mat_reg[1] : mat_reg[3];
                        dec_neg  = t_reg[0];
                    end
                    3'd1:
                    begin
                        dec_direct = 1'b1;
                        dec_x      = mat_reg[3];
                    end
                    3'd2:
                    begin
                        dec_direct = 1'b1;
                        dec_neg    = 1'b1;
                        dec_x      = mat_reg[1];
                    end
                    3'd3:
                    begin
                        dec_direct = 1'b1;
                        dec_neg    = 1'b1;
                        dec_x      = mat_reg[2];
                    end
                    3'd4:
                    begin
                        dec_direct = 1'b1;
                        dec_x      = mat_reg[0];
                    end
                    3'd5:
                    begin
                        dec_last = 2'd1;
                        dec_x    = t_reg[0] ? mat_reg[4] : mat_reg[2];
                        dec_y    = t_reg[0] ? mat_reg[3] : mat_reg[5];
                        dec_neg  = t_reg[0];
                    end
                    default:
                    begin
                        // Last numerator: negate the finished sum in a third pass.
                        dec_last = 2'd2;
                        if (t_reg == 2'd2)
                        begin
                            dec_direct = 1'b1;
                            dec_neg    = 1'b1;
                            dec_base0  = 1'b1;
                            dec_x      = acc_reg;
                        end
                        else
                        begin
                            dec_x   = t_reg[0] ? mat_reg[1] : mat_reg[0];
                            dec_y   = t_reg[0] ? mat_reg[4] : mat_reg[5];
                            dec_neg = t_reg[0];
                        end
                    end
                endcase
            end
        endcase
    end

    assign mac_val  = addsat(dec_base0 ? coef_t'('0) : acc_reg,
                             dec_neg ? negsat(prod_reg) : prod_reg);
    assign mac_fin  = (state_reg == ST_MAC) && ph_reg && (t_reg == dec_last);
    assign prog_fin = mac_fin && dec_jend;
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    assign ud     = magw(det_reg);
    assign trial  = {rem_reg, dvd_reg[QW-1]};
    assign diff   = trial - {1'b0, ud};
    assign div_ge = (trial >= {1'b0, ud});

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == CMD_APPEND || s_tuser == CMD_TRANSLATE ||
                        s_tuser == CMD_APPLY || s_tuser == CMD_INVERT)
                    begin
                        state_next = ST_MAC;
                    end
                    else if (s_tuser == CMD_ROTATE)
                    begin
                        state_next = ST_CORDIC;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CORDIC:
            begin
                if (ci_reg == CIW'(NSTEP - 1))
                begin
                    state_next = ST_CFIN;
                end
            end
            ST_CFIN:
            begin
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (prog_fin)
                begin
                    unique case (prog_reg)
                        PR_APPEND: state_next = ST_COMMIT;
                        PR_APPLY:  state_next = ST_DONE;
                        default:   state_next = (det_reg == '0) ? ST_DONE : ST_DLOAD;
                    endcase
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_DONE;
            end
            ST_DLOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (dcnt_reg == DCW'(1))
                begin
                    state_next = (dk_reg == 3'd5) ? ST_DONE : ST_DLOAD;
                end
            end
            default:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Datapath and output updates.
    always_comb
    begin
        logic signed [ANGLE_W-1:0] ang;
        logic signed [CW-1:0]      z0, sx, sy, at, rx, ry;
        coef_t                     cs, sn, rv;
        prog_next     = prog_reg;
        cmd_next      = cmd_reg;
        j_next        = j_reg;
        t_next        = t_reg;
        ph_next       = ph_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        mat_next      = mat_reg;
        op_next       = op_reg;
        tmp_next      = tmp_reg;
        num_next      = num_reg;
        inv_next      = inv_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        det_next      = det_reg;
        sing_next     = sing_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        ci_next       = ci_reg;
        flip_next     = flip_reg;
        dvd_next      = dvd_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        dk_next       = dk_reg;
        dneg_next     = dneg_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        ang = $signed(s_tdata[FIELD_W*8 +: ANGLE_W]);
        if (ang > ANGLE_LIMIT)
        begin
            ang = ANGLE_LIMIT;
        end
        if (ang < -ANGLE_LIMIT)
        begin
            ang = -ANGLE_LIMIT;
        end
        z0 = CW'(ang) <<< 14;
        sx = cx_reg >>> ci_reg;
        sy = cy_reg >>> ci_reg;
        at = CW'(ATAN_Q30[ci_reg]);
        rx = (cx_reg + (CW'(1) <<< (29 - F))) >>> (30 - F);
        ry = (cy_reg + (CW'(1) <<< (29 - F))) >>> (30 - F);
        if (flip_reg)
        begin
            rx = -rx;
            ry = -ry;
        end
        cs = sat64(64'(rx));
        sn = sat64(64'(ry));
        rv = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next     = s_tuser;
                    j_next       = '0;
                    t_next       = '0;
                    ph_next      = 1'b0;
                    sing_next    = 1'b0;
                    px_next      = in_px;
                    py_next      = in_py;
                    prog_next    = PR_APPEND;
                    ci_next      = '0;
                    cx_next      = CORDIC_GAIN;
                    cy_next      = '0;
                    cz_next      = z0;
                    flip_next    = 1'b0;
                    if (z0 > HALF_PI_Q30)
                    begin
                        cz_next   = z0 - PI_Q30;
                        flip_next = 1'b1;
                    end
                    else if (z0 < -HALF_PI_Q30)
                    begin
                        cz_next   = z0 + PI_Q30;
                        flip_next = 1'b1;
                    end
                    unique case (s_tuser)
                        CMD_IDENTITY:
                        begin
                            mat_next = '{ONE_C, '0, '0, ONE_C, '0, '0};
                        end
                        CMD_LOAD:
                        begin
                            mat_next = in_arg;
                        end
                        CMD_APPEND:
                        begin
                            op_next = in_arg;
                        end
                        CMD_TRANSLATE:
                        begin
                            op_next = '{ONE_C, '0, '0, ONE_C, in_px, in_py};
                        end
                        CMD_APPLY:
                        begin
                            prog_next = PR_APPLY;
                        end
                        CMD_INVERT:
                        begin
                            prog_next = PR_INV;
                        end
                        default:
                        begin
                            prog_next = PR_APPEND;
                        end
                    endcase
                end
            end
            ST_CORDIC:
            begin
                if (!cz_reg[CW-1])
                begin
                    cx_next = cx_reg - sy;
                    cy_next = cy_reg + sx;
                    cz_next = cz_reg - at;
                end
                else
                begin
                    cx_next = cx_reg + sy;
                    cy_next = cy_reg - sx;
                    cz_next = cz_reg + at;
                end
                ci_next = ci_reg + CIW'(1);
            end
            ST_CFIN:
            begin
                op_next   = '{cs, sn, negsat(sn), cs, '0, '0};
                prog_next = PR_APPEND;
                j_next    = '0;
                t_next    = '0;
                ph_next   = 1'b0;
            end
            ST_MAC:
            begin
                if (!ph_reg)
                begin
                    prod_next = dec_direct ? dec_x : mulq(dec_x, dec_y);
                    ph_next   = 1'b1;
                end
                else
                begin
                    acc_next = mac_val;
                    ph_next  = 1'b0;
                    if (t_reg == dec_last)
                    begin
                        t_next = '0;
                        j_next = j_reg + 3'd1;
                        unique case (prog_reg)
                            PR_APPEND:
                            begin
                                tmp_next[j_reg] = mac_val;
                            end
                            PR_APPLY:
                            begin
                                if (j_reg[0])
                                begin
                                    oy_next = mac_val;
                                end
                                else
                                begin
                                    ox_next = mac_val;
                                end
                            end
                            default:
                            begin
                                if (j_reg == 3'd0)
                                begin
                                    det_next = mac_val;
                                end
                                else
                                begin
                                    num_next[j_reg - 3'd1] = mac_val;
                                end
                            end
                        endcase
                        if (prog_fin && prog_reg == PR_INV)
                        begin
                            dk_next = '0;
                            if (det_reg == '0)
                            begin
                                sing_next = 1'b1;
                                inv_next  = '{ONE_C, '0, '0, ONE_C, '0, '0};
                            end
                        end
                    end
                    else
                    begin
                        t_next = t_reg + 2'd1;
                    end
                end
            end
            ST_COMMIT:
            begin
                mat_next = tmp_reg;
            end
            ST_DLOAD:
            begin
                dvd_next  = {magw(num_reg[dk_reg]), {F{1'b0}}};
                rem_next  = '0;
                quo_next  = '0;
                dcnt_next = DCW'(QW);
                dneg_next = num_reg[dk_reg][W-1] ^ det_reg[W-1];
            end
            ST_DIV:
            begin
                rem_next  = div_ge ? diff[W-1:0] : trial[W-1:0];
                quo_next  = {quo_reg[QW-2:0], div_ge};
                dvd_next  = dvd_reg << 1;
                dcnt_next = dcnt_reg - DCW'(1);
                if (dcnt_reg == DCW'(1))
                begin
                    inv_next[dk_reg] = ssat(SW'({quo_reg[QW-2:0], div_ge}), dneg_reg);
                    dk_next          = dk_reg + 3'd1;
                end
            end
            default:
            begin
                if (out_load)
                begin
                    m_tvalid_next = 1'b1;
                    for (int r = 0; r < 6; r++)
                    begin
                        rv = (cmd_reg == CMD_INVERT) ? inv_reg[r] : mat_reg[r];
                        m_tdata_next[FIELD_W*r +: FIELD_W] = sat32(rv);
                    end
                    m_tdata_next[FIELD_W*6 +: FIELD_W] =
                        (cmd_reg == CMD_APPLY) ? sat32(ox_reg) : '0;
                    m_tdata_next[FIELD_W*7 +: FIELD_W] =
                        (cmd_reg == CMD_APPLY) ? sat32(oy_reg) : '0;
                    m_tuser_next = {mat_ident, (cmd_reg == CMD_INVERT) && sing_reg};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            mat_reg      <= '{ONE_C, '0, '0, ONE_C, '0, '0};
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            mat_reg      <= mat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prog_reg    <= prog_next;
        cmd_reg     <= cmd_next;
        j_reg       <= j_next;
        t_reg       <= t_next;
        ph_reg      <= ph_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        op_reg      <= op_next;
        tmp_reg     <= tmp_next;
        num_reg     <= num_next;
        inv_reg     <= inv_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        det_reg     <= det_next;
        sing_reg    <= sing_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        ci_reg      <= ci_next;
        flip_reg    <= flip_next;
        dvd_reg     <= dvd_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dcnt_reg    <= dcnt_next;
        dk_reg      <= dk_next;
        dneg_reg    <= dneg_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    `AMT_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "busy after accept")
    `AMT_ASSERT_IMP(a_div_count_live, state_reg == ST_DIV, dcnt_reg != '0, "empty divide count")
    `AMT_ASSERT_IMP(a_cordic_in_range, state_reg == ST_CORDIC, ci_reg <= CIW'(NSTEP - 1), "bad step")
    `AMT_ASSERT_IMP(a_singular_identity, m_tvalid && m_tuser[0], m_tdata[95:32] == '0, "not identity")

endmodule
